/* sv/assert_macros.svh */
// assertion macros used by the checker file spq_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define SPQ_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define SPQ_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/spq_pkg.sv */
// shared types and constants of the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_INS_FULL  = 2'd2;

  typedef struct packed {
    logic       insert_en;
    logic       pop_en;
    logic       load_rsp;
    logic [1:0] status;
  } spq_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } spq_stat_t;

endpackage

/* sv/spq_req_if.sv */
// request channel: command and value with valid/ready
// depends on spq_pkg
interface spq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [spq_pkg::VAL_W-1:0]  value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

/* sv/spq_rsp_if.sv */
// response channel: queue snapshot and status with valid/ready
// depends on spq_pkg
interface spq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [spq_pkg::VAL_W-1:0]  front_value;
  logic signed [spq_pkg::VAL_W-1:0]  rear_value;
  logic [4:0]                        entry_count;
  logic                              is_empty;
  logic [1:0]                        status;

  modport source (output valid, front_value, rear_value, entry_count, is_empty, status,
                  input ready);
  modport sink (input valid, front_value, rear_value, entry_count, is_empty, status,
                output ready);
endinterface

/* sv/spq_ctrl.sv */
// controller: handshake, command decode and status code
// depends on spq_pkg
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_command,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctrl_t ctrl
);

  typedef enum logic {ST_IDLE, ST_HOLD} state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // a waiting result leaves in the same cycle a new beat comes in
  assign req_ready = (state == ST_IDLE) || rsp_ready;
  assign rsp_valid = (state == ST_HOLD);
  assign accept    = req_valid && req_ready;

  always_comb begin
    ctrl           = '0;
    ctrl.load_rsp  = accept;
    ctrl.status    = spq_pkg::STATUS_OK;
    if (req_command == spq_pkg::CMD_INSERT) begin
      if (stat.full) begin
        ctrl.status = spq_pkg::STATUS_INS_FULL;
      end else begin
        ctrl.insert_en = accept;
      end
    end else begin
      if (stat.empty) begin
        ctrl.status = spq_pkg::STATUS_POP_EMPTY;
      end else begin
        ctrl.pop_en = accept;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/spq_datapath.sv */
// datapath: sorted entry row, count, rear tracker and response register
// depends on spq_pkg
module spq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::spq_ctrl_t                ctrl,
  output spq_pkg::spq_stat_t                stat,
  input  logic signed [spq_pkg::VAL_W-1:0]  value,
  output logic signed [spq_pkg::VAL_W-1:0]  front_value,
  output logic signed [spq_pkg::VAL_W-1:0]  rear_value,
  output logic [4:0]                        entry_count,
  output logic                              is_empty,
  output logic [1:0]                        status
);

  logic signed [spq_pkg::VAL_W-1:0] entries      [spq_pkg::DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] entries_next [spq_pkg::DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] rear;
  logic signed [spq_pkg::VAL_W-1:0] rear_next;
  logic [spq_pkg::CNT_W-1:0]        count;
  logic [spq_pkg::CNT_W-1:0]        count_next;
  logic [spq_pkg::DEPTH-1:0]        valid;
  logic [spq_pkg::DEPTH-1:0]        shift;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == spq_pkg::CNT_W'(spq_pkg::DEPTH));

  // every cell compares against the new value in parallel
  for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
    assign valid[g] = (count > spq_pkg::CNT_W'(g));
    assign shift[g] = valid[g] && (value < entries[g]);

    logic signed [spq_pkg::VAL_W-1:0] pop_src;
    if (g < spq_pkg::DEPTH - 1) begin : g_pop
      assign pop_src = entries[g+1];
    end else begin : g_pop_last
      assign pop_src = entries[g];
    end

    if (g == 0) begin : g_first
      always_comb begin
        entries_next[g] = entries[g];
        if (ctrl.insert_en) begin
          if (shift[g] || !valid[g]) entries_next[g] = value;
        end else if (ctrl.pop_en) begin
          entries_next[g] = pop_src;
        end
      end
    end else begin : g_rest
      always_comb begin
        entries_next[g] = entries[g];
        if (ctrl.insert_en) begin
          if (shift[g-1]) begin
            entries_next[g] = entries[g-1];
          end else if ((shift[g] || !valid[g]) && valid[g-1]) begin
            // insertion point: previous cell stays, this one takes the value
            entries_next[g] = value;
          end
        end else if (ctrl.pop_en) begin
          entries_next[g] = pop_src;
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    rear_next  = rear;
    if (ctrl.insert_en) begin
      count_next = count + spq_pkg::CNT_W'(1);
      if (stat.empty || !(value < rear)) rear_next = value;
    end else if (ctrl.pop_en) begin
      count_next = count - spq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert_en || ctrl.pop_en) begin
      entries <= entries_next;
      rear    <= rear_next;
    end
  end

  // response snapshot of the state after the beat
  always_ff @(posedge clk) begin
    if (ctrl.load_rsp) begin
      front_value <= (count_next == '0) ? '0 : entries_next[0];
      rear_value  <= (count_next == '0) ? '0 : rear_next;
      entry_count <= 5'(count_next);
      is_empty    <= (count_next == '0);
      status      <= ctrl.status;
    end
  end

endmodule

/* sv/sorted_priority_queue.sv */
// top level of the sorted priority queue
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl, spq_datapath
//
// usage:
//   req channel carries one beat per operation: command 0 inserts value at
//   its sorted place (after equal values), command 1 pops the smallest entry.
//   rsp channel returns exactly one beat per request: smallest and largest
//   stored values (0 when empty), entry count, empty flag and status
//   (0 ok, 1 pop on empty ignored, 2 insert on full dropped).
// latency: the response is valid the cycle after the request is accepted.
// throughput: one operation per cycle while the receiver takes each response;
//   every cell of the sorted register row compares against the new value in
//   the same cycle, and the response register turns over each cycle.
// stall: while a response waits, req ready follows rsp ready, so a new beat
//   is taken in the cycle the waiting response leaves.
// reset: synchronous, clears the count and the pending response; entry
//   contents are not cleared and are never shown before they are written.
module sorted_priority_queue (
  input logic        clk,
  input logic        rst,
  spq_req_if.sink    req,
  spq_rsp_if.source  rsp
);

  spq_pkg::spq_ctrl_t ctrl;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .stat        (stat),
    .ctrl        (ctrl)
  );

  spq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .value       (req.value),
    .front_value (rsp.front_value),
    .rear_value  (rsp.rear_value),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .status      (rsp.status)
  );

endmodule

/* sv/spq_checker.sv */
// port-level checks on the sorted priority queue, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] front_value,
  input logic [31:0] rear_value,
  input logic [4:0]  entry_count,
  input logic        is_empty
);

  logic        stalled;
  logic        count_zero;
  logic        ends_zero;
  logic        ends_ordered;
  logic [69:0] beat;

  assign stalled      = rsp_valid && !rsp_ready;
  assign count_zero   = (entry_count == 5'd0);
  assign ends_zero    = (front_value == 32'd0) && (rear_value == 32'd0);
  assign ends_ordered = ($signed(front_value) <= $signed(rear_value));
  assign beat         = {front_value, rear_value, entry_count, is_empty};

  `SPQ_ASSERT_SAME(a_empty_flag, rsp_valid, is_empty == count_zero, "empty flag mismatch")
  `SPQ_ASSERT_SAME(a_empty_zero, rsp_valid && is_empty, ends_zero, "nonzero ends when empty")
  `SPQ_ASSERT_SAME(a_order, rsp_valid && !is_empty, ends_ordered, "front above rear")
  `SPQ_ASSERT_NEXT(a_hold, stalled, rsp_valid && $stable(beat), "stalled beat changed")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_value (rsp.front_value),
  .rear_value  (rsp.rear_value),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty)
);
